FILE: sv/rpn_stack_calculator_macros.svh
// ----------------------------------------------------------------------------
// rpn_stack_calculator_macros
// Assertion macros for the postfix calculator.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define RPN_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define RPN_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rpnc_pkg.sv
// ----------------------------------------------------------------------------
// rpnc_pkg
// Shared types and constants of the postfix calculator.
// ----------------------------------------------------------------------------
package rpnc_pkg;

    localparam int unsigned STACK_DEPTH = 128;
    localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SA_W = $clog2(STACK_DEPTH);
    localparam int unsigned NUM_VARS = 26;
    localparam int unsigned VA_W = 5;
    localparam logic [VA_W-1:0] NO_VAR = 5'd26;

    typedef enum logic [3:0] {
        OP_NUM = 4'd0,
        OP_VAR = 4'd1,
        OP_ASSIGN = 4'd2,
        OP_FORCE = 4'd3,
        OP_ADD = 4'd4,
        OP_SUB = 4'd5,
        OP_MUL = 4'd6,
        OP_DIV = 4'd7,
        OP_EOL = 4'd8
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP1,
        ST_POP2,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_DIVEND,
        ST_EOLCHK,
        ST_PUSH,
        ST_DONE
    } state_t;

endpackage

FILE: sv/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Postfix calculator on tokenized requests with a value stack in RAM.
// ----------------------------------------------------------------------------
// A request runs from IDLE to DONE through its pops, the multiply or divide
// states, and PUSH or the end-of-line check, as its opcode needs. The divide
// is a restoring divider that produces one quotient bit per cycle over 96
// steps after a set-up step; a divide by zero goes from POP1 straight to DONE.
// A result that waits on out_stall holds the input stalled until it is taken.
// The value stack lives in one RAM with a registered read; variables sit in
// registers with a valid bit each, so that reset clears them at once.
module rpn_stack_calculator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  opcode,
    input  logic signed [63:0] number_value,
    input  logic [4:0]  var_index,
    input  logic        confirm_overwrite,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        print_valid,
    output logic signed [63:0] print_value,
    output logic        stack_empty_err,
    output logic        stack_full_err,
    output logic        zero_divide_err,
    output logic        unknown_err,
    output logic        var_written
);

    `include "rpn_stack_calculator_macros.svh"

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

    rpnc_pkg::state_t state_reg, state_next;
    logic [3:0]  op_reg;
    logic [4:0]  idx_reg;
    logic        conf_reg;
    logic [rpnc_pkg::SP_W-1:0] sp_reg, sp_next;
    logic [63:0] var_reg [rpnc_pkg::NUM_VARS];
    logic [rpnc_pkg::NUM_VARS-1:0] var_ok_reg;
    logic [4:0]  last_reg;
    logic        asg_reg, vpend_reg, force_reg;
    logic [63:0] pend_reg;
    logic [63:0] x_reg, y_reg, res_reg;
    logic        xv_reg, yv_reg;
    logic [63:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [63:0] rem_reg, q_reg, ma_reg, mb_reg;
    logic        ovf_reg, neg_reg;
    logic [6:0]  cnt_reg;
    logic        out_valid_reg;
    logic        pv_reg, emp_reg, full_reg, zd_reg, unk_reg, wr_reg;
    logic [63:0] pval_reg;

    logic        ram_we;
    logic [rpnc_pkg::SA_W-1:0] ram_waddr, ram_raddr;
    logic [63:0] ram_wdata, ram_rdata;

    logic        accept;
    logic [63:0] mag_x, mag_y, rem_sh, qsat, mid, hi, lo, mulr;
    logic        carry, mul_ovf;
    logic [63:0] pop_val;
    logic [4:0]  lv;
    logic [63:0] lv_val;
    logic        eol_asg;

    function automatic logic [63:0] sat(input logic neg, input logic [63:0] m,
                                        input logic ovf);
        logic [63:0] r;
        if (!neg)
        begin
            r = (ovf || m > POS_MAX) ? POS_MAX : m;
        end
        else
        begin
            r = (ovf || m > NEG_MAX) ? NEG_MAX : (64'd0 - m);
        end
        return r;
    endfunction

    rpnc_ram #(.WIDTH(64), .DEPTH(rpnc_pkg::STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != rpnc_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign print_valid = pv_reg;
    assign print_value = pval_reg;
    assign stack_empty_err = emp_reg;
    assign stack_full_err = full_reg;
    assign zero_divide_err = zd_reg;
    assign unknown_err = unk_reg;
    assign var_written = wr_reg;

    assign ram_raddr = rpnc_pkg::SA_W'(sp_reg - 1'b1);
    assign pop_val = ram_rdata;
    assign lv = last_reg;
    assign lv_val = (lv < 5'd26 && var_ok_reg[lv]) ? var_reg[lv] : 64'd0;
    assign eol_asg = lv < 5'd26 && asg_reg && vpend_reg;

    assign mag_x = x_reg[63] ? (64'd0 - x_reg) : x_reg;
    assign mag_y = y_reg[63] ? (64'd0 - y_reg) : y_reg;
    assign carry = rem_reg[63];
    assign rem_sh = {rem_reg[62:0], (cnt_reg >= 7'd32) ? ma_reg[6'(cnt_reg - 7'd32)] : 1'b0};
    assign mid = {32'd0, p0_reg[63:32]} + {32'd0, p1_reg[31:0]} + {32'd0, p2_reg[31:0]};
    assign hi = p3_reg + {32'd0, p1_reg[63:32]} + {32'd0, p2_reg[63:32]} + {32'd0, mid[63:32]};
    assign lo = {mid[31:0], p0_reg[31:0]};
    assign mulr = {hi[31:0], lo[63:32]};
    assign mul_ovf = hi[63:32] != 32'd0;
    assign qsat = sat(neg_reg, q_reg, ovf_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpnc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (opcode == rpnc_pkg::OP_ADD || opcode == rpnc_pkg::OP_SUB ||
                                 opcode == rpnc_pkg::OP_MUL || opcode == rpnc_pkg::OP_DIV)
                    begin
                        state_next = rpnc_pkg::ST_POP1;
                    end
                    else if (opcode == rpnc_pkg::OP_EOL)
                    begin
                        state_next = rpnc_pkg::ST_EOLCHK;
                    end
                    else if (opcode == rpnc_pkg::OP_NUM || opcode == rpnc_pkg::OP_VAR)
                    begin
                        state_next = rpnc_pkg::ST_PUSH;
                    end
                    else
                    begin
                        state_next = rpnc_pkg::ST_DONE;
                    end
                end
            end
            rpnc_pkg::ST_POP1:
            begin
                if (op_reg == rpnc_pkg::OP_DIV && yv_reg && pop_val == 64'd0)
                begin
                    state_next = rpnc_pkg::ST_DONE;
                end
                else if (op_reg == rpnc_pkg::OP_DIV && !yv_reg)
                begin
                    state_next = rpnc_pkg::ST_DONE;
                end
                else
                begin
                    state_next = rpnc_pkg::ST_POP2;
                end
            end
            rpnc_pkg::ST_POP2:
            begin
                unique case (op_reg)
                    rpnc_pkg::OP_MUL: state_next = rpnc_pkg::ST_MUL1;
                    rpnc_pkg::OP_DIV: state_next = rpnc_pkg::ST_DIV;
                    default:          state_next = rpnc_pkg::ST_PUSH;
                endcase
            end
            rpnc_pkg::ST_MUL1:   state_next = rpnc_pkg::ST_MUL2;
            rpnc_pkg::ST_MUL2:   state_next = rpnc_pkg::ST_PUSH;
            rpnc_pkg::ST_DIV:
            begin
                if (cnt_reg == 7'd0)
                begin
                    state_next = rpnc_pkg::ST_DIVEND;
                end
            end
            rpnc_pkg::ST_DIVEND: state_next = rpnc_pkg::ST_PUSH;
            rpnc_pkg::ST_EOLCHK: state_next = rpnc_pkg::ST_DONE;
            rpnc_pkg::ST_PUSH:   state_next = rpnc_pkg::ST_DONE;
            rpnc_pkg::ST_DONE:   state_next = rpnc_pkg::ST_IDLE;
            default:             state_next = rpnc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = rpnc_pkg::SA_W'(sp_reg);
        ram_wdata = res_reg;
        sp_next = sp_reg;
        unique case (state_reg)
            rpnc_pkg::ST_IDLE:
            begin
                if (accept && opcode >= rpnc_pkg::OP_ADD && opcode <= rpnc_pkg::OP_DIV &&
                    sp_reg != '0)
                begin
                    sp_next = sp_reg - 1'b1;
                end
            end
            rpnc_pkg::ST_POP1:
            begin
                if (!(op_reg == rpnc_pkg::OP_DIV && (!yv_reg || pop_val == 64'd0)) &&
                    sp_reg != '0)
                begin
                    sp_next = sp_reg - 1'b1;
                end
            end
            rpnc_pkg::ST_EOLCHK:
            begin
                if ((!eol_asg || (lv_val != 64'd0 && !force_reg)) && sp_reg != '0)
                begin
                    sp_next = sp_reg - 1'b1;
                end
            end
            rpnc_pkg::ST_PUSH:
            begin
                if (!(op_reg == rpnc_pkg::OP_NUM && asg_reg) &&
                    !(op_reg == rpnc_pkg::OP_VAR && idx_reg > 5'd25) &&
                    sp_reg < rpnc_pkg::SP_W'(rpnc_pkg::STACK_DEPTH))
                begin
                    ram_we = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpnc_pkg::ST_IDLE;
            sp_reg <= '0;
            var_ok_reg <= '0;
            last_reg <= rpnc_pkg::NO_VAR;
            asg_reg <= 1'b0;
            vpend_reg <= 1'b0;
            force_reg <= 1'b0;
            pend_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                rpnc_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg <= opcode;
                        idx_reg <= var_index;
                        conf_reg <= confirm_overwrite;
                        pv_reg <= 1'b0;
                        emp_reg <= 1'b0;
                        full_reg <= 1'b0;
                        zd_reg <= 1'b0;
                        unk_reg <= opcode > rpnc_pkg::OP_EOL;
                        wr_reg <= 1'b0;
                        pval_reg <= '0;
                        yv_reg <= sp_reg != '0;
                        if (opcode == rpnc_pkg::OP_ASSIGN)
                        begin
                            asg_reg <= 1'b1;
                        end
                        if (opcode == rpnc_pkg::OP_FORCE)
                        begin
                            force_reg <= 1'b1;
                        end
                        if (opcode == rpnc_pkg::OP_VAR && var_index < 5'd26)
                        begin
                            res_reg <= var_ok_reg[var_index] ? var_reg[var_index] : 64'd0;
                            last_reg <= var_index;
                        end
                        else
                        begin
                            res_reg <= number_value;
                        end
                        if (opcode == rpnc_pkg::OP_NUM && asg_reg)
                        begin
                            pend_reg <= number_value[63] ?
                                (64'd0 - ((64'd0 - number_value) & 64'hFFFF_FFFF_0000_0000)) :
                                (number_value & 64'hFFFF_FFFF_0000_0000);
                            vpend_reg <= 1'b1;
                        end
                    end
                end
                rpnc_pkg::ST_POP1:
                begin
                    y_reg <= yv_reg ? pop_val : 64'd0;
                    emp_reg <= !yv_reg;
                    xv_reg <= sp_reg != '0;
                    if (op_reg == rpnc_pkg::OP_DIV && (!yv_reg || pop_val == 64'd0))
                    begin
                        zd_reg <= 1'b1;
                    end
                end
                rpnc_pkg::ST_POP2:
                begin
                    x_reg <= xv_reg ? pop_val : 64'd0;
                    if (!xv_reg)
                    begin
                        emp_reg <= 1'b1;
                    end
                end
                rpnc_pkg::ST_MUL1:
                begin
                    p0_reg <= mag_x[31:0] * mag_y[31:0];
                    p1_reg <= mag_x[31:0] * mag_y[63:32];
                    p2_reg <= mag_x[63:32] * mag_y[31:0];
                    p3_reg <= mag_x[63:32] * mag_y[63:32];
                end
                rpnc_pkg::ST_MUL2:
                begin
                    res_reg <= sat(x_reg[63] ^ y_reg[63], mulr, mul_ovf);
                end
                rpnc_pkg::ST_DIV:
                begin
                    if (cnt_reg == 7'd127)
                    begin
                        ma_reg <= mag_x;
                        mb_reg <= mag_y;
                        neg_reg <= x_reg[63] ^ y_reg[63];
                        rem_reg <= '0;
                        q_reg <= '0;
                        ovf_reg <= 1'b0;
                        cnt_reg <= 7'd95;
                    end
                    else
                    begin
                        if (carry || rem_sh >= mb_reg)
                        begin
                            rem_reg <= rem_sh - mb_reg;
                            q_reg <= {q_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            q_reg <= {q_reg[62:0], 1'b0};
                        end
                        if (q_reg[63])
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (cnt_reg != 7'd0)
                        begin
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                    end
                end
                rpnc_pkg::ST_DIVEND:
                begin
                    res_reg <= qsat;
                end
                rpnc_pkg::ST_EOLCHK:
                begin
                    if (eol_asg)
                    begin
                        if (lv_val != 64'd0 && !force_reg)
                        begin
                            if (sp_reg == '0)
                            begin
                                emp_reg <= 1'b1;
                            end
                            if (conf_reg)
                            begin
                                var_reg[lv] <= pend_reg;
                                var_ok_reg[lv] <= 1'b1;
                                wr_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            var_reg[lv] <= pend_reg;
                            var_ok_reg[lv] <= 1'b1;
                            wr_reg <= 1'b1;
                        end
                        force_reg <= 1'b0;
                    end
                    else
                    begin
                        pv_reg <= 1'b1;
                        if (sp_reg != '0)
                        begin
                            pval_reg <= pop_val;
                        end
                        else
                        begin
                            emp_reg <= 1'b1;
                        end
                    end
                    last_reg <= rpnc_pkg::NO_VAR;
                    asg_reg <= 1'b0;
                    vpend_reg <= 1'b0;
                    pend_reg <= '0;
                end
                rpnc_pkg::ST_PUSH:
                begin
                    if (!(op_reg == rpnc_pkg::OP_NUM && asg_reg) &&
                        !(op_reg == rpnc_pkg::OP_VAR && idx_reg > 5'd25) &&
                        sp_reg >= rpnc_pkg::SP_W'(rpnc_pkg::STACK_DEPTH))
                    begin
                        full_reg <= 1'b1;
                    end
                end
                rpnc_pkg::ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
            if (state_reg == rpnc_pkg::ST_POP2)
            begin
                cnt_reg <= 7'd127;
                unique case (op_reg)
                    rpnc_pkg::OP_ADD:
                        res_reg <= ((xv_reg ? pop_val[63] : 1'b0) == y_reg[63] &&
                                    ((xv_reg ? pop_val : 64'd0) + y_reg) >> 63 !=
                                    {63'd0, y_reg[63]}) ?
                                   (y_reg[63] ? NEG_MAX : POS_MAX) :
                                   ((xv_reg ? pop_val : 64'd0) + y_reg);
                    rpnc_pkg::OP_SUB:
                        res_reg <= ((xv_reg ? pop_val[63] : 1'b0) != y_reg[63] &&
                                    ((xv_reg ? pop_val : 64'd0) - y_reg) >> 63 !=
                                    {63'd0, (xv_reg ? pop_val[63] : 1'b0)}) ?
                                   ((xv_reg ? pop_val[63] : 1'b0) ? NEG_MAX : POS_MAX) :
                                   ((xv_reg ? pop_val : 64'd0) - y_reg);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    `RPN_ASSERT_IMPL(a_sp_bound, 1'b1,
        sp_reg <= rpnc_pkg::SP_W'(rpnc_pkg::STACK_DEPTH), "stack pointer beyond depth")
    `RPN_ASSERT_IMPL(a_idle_only, accept, state_reg == rpnc_pkg::ST_IDLE,
        "request accepted while busy")
    `RPN_ASSERT_NEXT(a_done_out, state_reg == rpnc_pkg::ST_DONE, out_valid_reg,
        "result not presented after completion")
    `RPN_ASSERT_IMPL(a_one_flag, out_valid_reg, !(pv_reg && wr_reg),
        "print and variable write together")

endmodule

FILE: sv/rpnc_ram.sv
// ----------------------------------------------------------------------------
// rpnc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rpnc_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
